FILE: hdl/skp_pkg.sv
// ----------------------------------------------------------------------------
// skp_pkg
// shared types, constants and helpers for the skyline rectangle packer
// ----------------------------------------------------------------------------
package skp_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int HEIGHT_BITS_DEF = 12;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int AREA_W     = 22;

  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATLAS_WIDTH  = 2'd0,
    REG_ATLAS_HEIGHT = 2'd1,
    REG_BORDER_SIZE  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_CLEAR = 1'b1
  } item_cmd_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_CHECK,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_PEAK_RD,
    ST_PEAK_EV,
    ST_RUN_END,
    ST_FINISH,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic clr_fin;
    logic rd_peak;
    logic skip;
    logic peak_start;
    logic peak_eval;
    logic run_end;
    logic fail;
    logic commit;
    logic wr_step;
    logic emit;
    logic emit_placed;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic clr_last;
    logic reject;
    logic scan_done;
    logic eq_last;
    logic peak_last;
    logic no_fit;
    logic wr_last;
  } dp_status_t;

  // smallest power of two not below v, 1 for v of 0 or 1
  function automatic logic [18:0] pow2_up(input logic [17:0] v);
    logic [18:0] r;
    r = 19'd1 << 18;
    for (int i = 18; i >= 0; i--) begin
      if ((19'd1 << i) >= {1'b0, v}) r = 19'd1 << i;
    end
    return r;
  endfunction

endpackage

FILE: hdl/skp_ctrl.sv
// ----------------------------------------------------------------------------
// skp_ctrl
// sequencer for clear sweeps, skyline scan, height check and column rewrite
// ----------------------------------------------------------------------------
module skp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  skp_pkg::dp_status_t status_i,
  output skp_pkg::dp_cmd_t    cmd_o
);
  import skp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_INIT: begin
        // packer registers already hold their reset values
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.is_clear ? ST_CLR : ST_CHECK;
        end
      end
      ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          cmd_o.clr_fin = 1'b1;
          cmd_o.emit    = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (status_i.reject) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        state_d = status_i.scan_done ? ST_FINISH : ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        if (status_i.eq_last) begin
          cmd_o.skip = 1'b1;
          state_d    = ST_SCAN_RD;
        end else begin
          cmd_o.peak_start = 1'b1;
          state_d          = ST_PEAK_RD;
        end
      end
      ST_PEAK_RD: begin
        cmd_o.rd_peak = 1'b1;
        state_d       = ST_PEAK_EV;
      end
      ST_PEAK_EV: begin
        cmd_o.peak_eval = 1'b1;
        state_d         = status_i.peak_last ? ST_RUN_END : ST_PEAK_RD;
      end
      ST_RUN_END: begin
        cmd_o.run_end = 1'b1;
        state_d       = ST_SCAN_RD;
      end
      ST_FINISH: begin
        if (status_i.no_fit) begin
          cmd_o.fail = 1'b1;
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.wr_step = 1'b1;
        if (status_i.wr_last) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_placed = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

FILE: hdl/skp_dpath.sv
// ----------------------------------------------------------------------------
// skp_dpath
// skyline memory, configuration, scan registers, extents and result registers
// ----------------------------------------------------------------------------
module skp_dpath #(
  parameter int MAX_COLUMNS = skp_pkg::MAX_COLUMNS_DEF,
  parameter int HEIGHT_BITS = skp_pkg::HEIGHT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [skp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [skp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           cmd_i,
  input  logic [11:0]                    block_width_i,
  input  logic [11:0]                    block_height_i,
  input  skp_pkg::dp_cmd_t               cmd_ctl_i,
  output skp_pkg::dp_status_t            status_o,
  output logic                           result_valid_o,
  output logic                           placed_o,
  output logic [10:0]                    pos_x_o,
  output logic [12:0]                    pos_y_o,
  output logic signed [11:0]             used_width_o,
  output logic signed [12:0]             used_height_o,
  output logic [10:0]                    used_width_pow2_o,
  output logic [12:0]                    used_height_pow2_o,
  output logic [skp_pkg::AREA_W-1:0]     area_total_o
);
  import skp_pkg::*;

  localparam int CW  = $clog2(MAX_COLUMNS + 1);
  localparam int AW  = $clog2(MAX_COLUMNS);
  localparam int HB  = HEIGHT_BITS;
  localparam int SW  = HB + 1;
  localparam int YS  = HB + 2;
  localparam int TW0 = (CW > HB) ? CW : HB;
  localparam int TW  = ((TW0 > 13) ? TW0 : 13) + 1;
  localparam int PW  = CW + HB;
  // effective atlas size for the register reset values
  localparam int RST_W = (1024 > MAX_COLUMNS) ? MAX_COLUMNS : 1024;
  localparam int RST_H = (1024 > (1 << HB) - 1) ? (1 << HB) - 1 : 1024;

  // configuration
  logic [10:0] atlas_width_q;
  logic [11:0] atlas_height_q;
  logic [3:0]  border_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_width_q  <= 11'd1024;
      atlas_height_q <= 12'd1024;
      border_q       <= 4'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ATLAS_WIDTH:  atlas_width_q  <= cfg_data_i[10:0];
        REG_ATLAS_HEIGHT: atlas_height_q <= cfg_data_i[11:0];
        REG_BORDER_SIZE:  border_q       <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // effective atlas size and padded, clamped block size
  logic [TW-1:0] w_eff, h_eff, pad_w, pad_h, w_clamp, h_clamp;

  always_comb begin
    w_eff = TW'(atlas_width_q);
    if (w_eff == '0) w_eff = TW'(1);
    if (w_eff > TW'(MAX_COLUMNS)) w_eff = TW'(MAX_COLUMNS);
    h_eff = TW'(atlas_height_q);
    if (h_eff == '0) h_eff = TW'(1);
    if (h_eff > TW'((1 << HB) - 1)) h_eff = TW'((1 << HB) - 1);
    pad_w   = TW'(block_width_i) + TW'({border_q, 1'b0});
    pad_h   = TW'(block_height_i) + TW'({border_q, 1'b0});
    w_clamp = (pad_w > w_eff) ? w_eff : pad_w;
    h_clamp = (pad_h > h_eff) ? h_eff : pad_h;
  end

  logic [CW-1:0] w_q;
  logic [HB-1:0] h_q;
  logic          is_clear_q;

  always_ff @(posedge clk_i) begin
    if (cmd_ctl_i.load) begin
      w_q        <= CW'(w_clamp);
      h_q        <= HB'(h_clamp);
      is_clear_q <= (cmd_i == CMD_CLEAR);
    end
  end

  // skyline memory
  logic signed [SW-1:0] sky_mem [MAX_COLUMNS];
  logic signed [SW-1:0] rdata_q;
  logic [AW-1:0]        clr_cnt_q;
  logic [CW-1:0]        x_q, pcur_q, pidx_q, best_q, wcnt_q;
  logic signed [YS-1:0] last_val_q, min_y_q, pbest_q;
  logic                 found_q;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic signed [SW-1:0] wr_data;
  logic                 wr_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_ctl_i.clr_step) begin
      clr_cnt_q <= status_o.clr_last ? '0 : clr_cnt_q + AW'(1);
    end
  end

  assign rd_addr = cmd_ctl_i.rd_peak ? pcur_q[AW-1:0] : x_q[AW-1:0];
  assign wr_en   = cmd_ctl_i.clr_step | cmd_ctl_i.wr_step;
  assign wr_addr = cmd_ctl_i.clr_step ? clr_cnt_q : wcnt_q[AW-1:0];

  logic signed [YS-1:0] top, fill;
  assign top     = min_y_q + YS'(1) + YS'(h_q);
  assign fill    = min_y_q + YS'(h_q);
  assign wr_data = cmd_ctl_i.clr_step ? '1 : SW'(fill);

  always_ff @(posedge clk_i) begin
    if (wr_en) sky_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= sky_mem[rd_addr];
  end

  logic signed [YS-1:0] rdv;
  assign rdv = YS'(rdata_q);

  // scan registers
  always_ff @(posedge clk_i) begin
    if (cmd_ctl_i.load) begin
      x_q        <= '0;
      last_val_q <= -YS'(2);
      min_y_q    <= YS'(h_eff);
      found_q    <= 1'b0;
    end
    if (cmd_ctl_i.skip) x_q <= x_q + CW'(1);
    if (cmd_ctl_i.peak_start) begin
      pcur_q  <= x_q;
      pidx_q  <= x_q;
      pbest_q <= -YS'(1);
    end
    if (cmd_ctl_i.peak_eval) begin
      if (rdv >= pbest_q) begin
        pbest_q <= rdv;
        pidx_q  <= pcur_q;
      end
      pcur_q <= pcur_q + CW'(1);
    end
    if (cmd_ctl_i.run_end) begin
      last_val_q <= pbest_q;
      if (min_y_q > pbest_q) begin
        min_y_q <= pbest_q;
        best_q  <= x_q;
        found_q <= 1'b1;
      end
      x_q <= pidx_q + CW'(1);
    end
    if (cmd_ctl_i.commit) wcnt_q <= best_q;
    if (cmd_ctl_i.wr_step) wcnt_q <= wcnt_q + CW'(1);
  end

  // packer state
  logic [CW:0]            failed_w_q;
  logic [HB:0]            failed_h_q;
  logic signed [CW:0]     extent_x_q;
  logic signed [YS-1:0]   extent_y_q;
  logic [AREA_W-1:0]      area_q;
  logic signed [CW:0]     right_edge;
  logic [PW-1:0]          prod;
  logic [PW:0]            area_sum;

  assign right_edge = $signed({1'b0, best_q}) + $signed({1'b0, w_q});
  assign prod       = PW'(w_q) * PW'(h_q);
  assign area_sum   = (PW + 1)'(prod) + (PW + 1)'(area_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      failed_w_q <= (CW + 1)'(RST_W + 1);
      failed_h_q <= (HB + 1)'(RST_H + 1);
      extent_x_q <= '1;
      extent_y_q <= '1;
      area_q     <= '0;
    end else begin
      if (cmd_ctl_i.clr_fin) begin
        failed_w_q <= (CW + 1)'(w_eff) + (CW + 1)'(1);
        failed_h_q <= (HB + 1)'(h_eff) + (HB + 1)'(1);
        extent_x_q <= '1;
        extent_y_q <= '1;
        area_q     <= '0;
      end
      if (cmd_ctl_i.fail) begin
        if (({1'b0, w_q} <= failed_w_q) && ({1'b0, h_q} <= failed_h_q)) begin
          failed_w_q <= {1'b0, w_q};
          failed_h_q <= {1'b0, h_q};
        end
      end
      if (cmd_ctl_i.commit) begin
        if (top > extent_y_q) extent_y_q <= top;
        if (right_edge > extent_x_q) extent_x_q <= right_edge;
        area_q <= (area_sum > (PW + 1)'(AREA_MAX)) ? AREA_MAX : AREA_W'(area_sum);
      end
    end
  end

  // status
  logic [CW-1:0]        last_x;
  logic signed [YS-1:0] h_bound;

  assign last_x  = CW'(w_eff) - w_q;
  assign h_bound = YS'(h_eff) - YS'(1);

  assign status_o.is_clear  = (cmd_i == CMD_CLEAR);
  assign status_o.clr_last  = (clr_cnt_q == AW'(MAX_COLUMNS - 1));
  assign status_o.reject    = (w_q == '0) || (h_q == '0) ||
                              (({1'b0, w_q} >= failed_w_q) && ({1'b0, h_q} >= failed_h_q));
  assign status_o.scan_done = (x_q > last_x);
  assign status_o.eq_last   = (rdv == last_val_q);
  assign status_o.peak_last = (pcur_q == x_q + w_q - CW'(1));
  assign status_o.no_fit    = !found_q || (top >= h_bound);
  assign status_o.wr_last   = (wcnt_q == best_q + w_q - CW'(1));

  // result registers
  logic [17:0] ext_x_pos, ext_y_pos;
  logic [18:0] pow_x, pow_y;

  assign ext_x_pos = extent_x_q[CW] ? 18'd0 : 18'(extent_x_q[CW-1:0]);
  assign ext_y_pos = extent_y_q[YS-1] ? 18'd0 : 18'(extent_y_q[YS-2:0]);
  assign pow_x     = pow2_up(ext_x_pos);
  assign pow_y     = pow2_up(ext_y_pos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_ctl_i.emit;
    end
  end

  // a clear reports the emptied state, which lands in the same edge
  always_ff @(posedge clk_i) begin
    if (cmd_ctl_i.emit) begin
      placed_o           <= cmd_ctl_i.emit_placed && !is_clear_q;
      pos_x_o            <= cmd_ctl_i.emit_placed ? 11'(best_q + CW'(border_q)) : '0;
      pos_y_o            <= cmd_ctl_i.emit_placed ?
                            13'(min_y_q + YS'(1) + YS'(border_q)) : '0;
      used_width_o       <= is_clear_q ? '1 : 12'(extent_x_q);
      used_height_o      <= is_clear_q ? '1 : 13'(extent_y_q);
      used_width_pow2_o  <= is_clear_q ? 11'd1 : pow_x[10:0];
      used_height_pow2_o <= is_clear_q ? 13'd1 : pow_y[12:0];
      area_total_o       <= is_clear_q ? '0 : area_q;
    end
  end

endmodule

FILE: hdl/skyline_rectangle_packer.sv
// ----------------------------------------------------------------------------
// skyline_rectangle_packer
// bottom-left skyline packer for texture atlas blocks
// ----------------------------------------------------------------------------
// usage: raise start with cmd, block_width and block_height; the transaction
// is taken at a clock edge where start is high and busy is low. each item
// answers with one result shown for a single cycle with result_valid_o high;
// the receiver cannot stall, so it must take the result in that cycle.
// configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
// the block is idle; index 0 atlas width, 1 atlas height, 2 border size.
// sequence: a clear sweeps all MAX_COLUMNS skyline entries, one per cycle,
// and its result follows the last entry. an add refused at once answers
// from its check step; otherwise it takes a check step, a read and an
// evaluation per scan position (each skipped column and each run start),
// a read and an evaluation per column of each run, a run end step, a step
// to end the scan, a decision step, a rewrite step per column when placed
// and the result register; the skyline memory has a separate write port and
// a registered read. one item at a time. after reset the same sweep runs
// with busy high and no result; configuration writes are taken during it.
// ----------------------------------------------------------------------------
module skyline_rectangle_packer #(
  parameter int MAX_COLUMNS = skp_pkg::MAX_COLUMNS_DEF,
  parameter int HEIGHT_BITS = skp_pkg::HEIGHT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [skp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [skp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cmd_i,
  input  logic [11:0]                    block_width_i,
  input  logic [11:0]                    block_height_i,
  output logic                           result_valid_o,
  output logic                           placed_o,
  output logic [10:0]                    pos_x_o,
  output logic [12:0]                    pos_y_o,
  output logic signed [11:0]             used_width_o,
  output logic signed [12:0]             used_height_o,
  output logic [10:0]                    used_width_pow2_o,
  output logic [12:0]                    used_height_pow2_o,
  output logic [skp_pkg::AREA_W-1:0]     area_total_o
);
  import skp_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  skp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (dp_status),
    .cmd_o    (dp_cmd)
  );

  skp_dpath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .cmd_i              (cmd_i),
    .block_width_i      (block_width_i),
    .block_height_i     (block_height_i),
    .cmd_ctl_i          (dp_cmd),
    .status_o           (dp_status),
    .result_valid_o     (result_valid_o),
    .placed_o           (placed_o),
    .pos_x_o            (pos_x_o),
    .pos_y_o            (pos_y_o),
    .used_width_o       (used_width_o),
    .used_height_o      (used_height_o),
    .used_width_pow2_o  (used_width_pow2_o),
    .used_height_pow2_o (used_height_pow2_o),
    .area_total_o       (area_total_o)
  );

  // an accepted transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // a result comes only out of a busy block that has just gone idle
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (!busy || $past(start)) && $past(busy))
    else $error("result strobe outside end of transaction");

  // results are single-cycle strobes
  a_result_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

endmodule

FILE: test/skp_checker.sv
// ----------------------------------------------------------------------------
// skp_checker
// watches the packer's item, config and result ports, predicts every result
// from a local copy of the skyline and compares field by field
// ----------------------------------------------------------------------------
module skp_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [skp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [skp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           cmd_i,
  input  logic [11:0]                    block_width_i,
  input  logic [11:0]                    block_height_i,
  input  logic                           result_valid_o,
  input  logic                           placed_o,
  input  logic [10:0]                    pos_x_o,
  input  logic [12:0]                    pos_y_o,
  input  logic [11:0]                    used_width_o,
  input  logic [12:0]                    used_height_o,
  input  logic [10:0]                    used_width_pow2_o,
  input  logic [12:0]                    used_height_pow2_o,
  input  logic [skp_pkg::AREA_W-1:0]     area_total_o,
  output int                             fail_cnt_o
);
  import skp_pkg::*;

  localparam int COLS     = 1024;
  localparam int H_LIMIT  = 4095;
  localparam int AREA_SAT = 4194303;

  typedef struct packed {
    logic        placed;
    logic [10:0] pos_x;
    logic [12:0] pos_y;
    logic [11:0] used_w;
    logic [12:0] used_h;
    logic [10:0] used_w_p2;
    logic [12:0] used_h_p2;
    logic [21:0] area;
  } placement_t;

  placement_t placement_q[$];

  int atlas_w, atlas_h, border;
  int sky[COLS];
  int fail_w, fail_h, ext_x, ext_y, area_acc;

  function automatic int clamp_w();
    return (atlas_w < 1) ? 1 : (atlas_w > COLS) ? COLS : atlas_w;
  endfunction

  function automatic int clamp_h();
    return (atlas_h < 1) ? 1 : (atlas_h > H_LIMIT) ? H_LIMIT : atlas_h;
  endfunction

  function automatic int round_pow2(input int v);
    int r;
    r = 1;
    while (r < v) r = r << 1;
    return r;
  endfunction

  task automatic wipe_skyline();
    for (int i = 0; i < COLS; i++) sky[i] = -1;
    fail_w   = clamp_w() + 1;
    fail_h   = clamp_h() + 1;
    ext_x    = -1;
    ext_y    = -1;
    area_acc = 0;
  endtask

  task automatic note_failure(input int w, input int h);
    if (w <= fail_w && h <= fail_h) begin
      fail_w = w;
      fail_h = h;
    end
  endtask

  // bottom-left placement over the lowest column run
  task automatic place_block(input int bw, input int bh, output bit ok,
                             output int px, output int py);
    int aw, ah, w, h, best_x, min_y, last_x, last_val, x, peak, pv, top;
    aw = clamp_w();
    ah = clamp_h();
    w = bw + 2 * border;
    h = bh + 2 * border;
    best_x = -1;
    min_y = ah;
    last_val = -2;
    ok = 0;
    px = 0;
    py = 0;
    if (w > aw) w = aw;
    if (h > ah) h = ah;
    if (w <= 0 || h <= 0) return;
    if (w >= fail_w && h >= fail_h) return;
    last_x = aw - w;
    x = 0;
    while (x <= last_x) begin
      if (sky[x] == last_val) begin
        x++;
      end else begin
        // highest column of the run, ties to the right
        pv = -1;
        peak = x;
        for (int c = x; c < x + w; c++) begin
          if (sky[c] >= pv) begin
            pv = sky[c];
            peak = c;
          end
        end
        last_val = sky[peak];
        if (min_y > last_val) begin
          min_y = last_val;
          best_x = x;
        end
        x = peak + 1;
      end
    end
    if (best_x < 0) begin
      note_failure(w, h);
      return;
    end
    top = min_y + 1 + h;
    if (top >= ah - 1) begin
      note_failure(w, h);
      return;
    end
    if (top > ext_y) ext_y = top;
    if (best_x + w > ext_x) ext_x = best_x + w;
    for (int c = best_x; c < best_x + w; c++) sky[c] = min_y + h;
    area_acc += w * h;
    if (area_acc > AREA_SAT) area_acc = AREA_SAT;
    ok = 1;
    px = best_x + border;
    py = min_y + 1 + border;
  endtask

  task automatic predict_placement(input logic cmd, input int bw, input int bh);
    placement_t p;
    bit ok;
    int px, py;
    ok = 0;
    px = 0;
    py = 0;
    if (item_cmd_e'(cmd) == CMD_CLEAR) wipe_skyline();
    else place_block(bw, bh, ok, px, py);
    p.placed    = ok;
    p.pos_x     = px[10:0];
    p.pos_y     = py[12:0];
    p.used_w    = ext_x[11:0];
    p.used_h    = ext_y[12:0];
    p.used_w_p2 = 11'(round_pow2(ext_x));
    p.used_h_p2 = 13'(round_pow2(ext_y));
    p.area      = area_acc[21:0];
    placement_q.push_back(p);
  endtask

  task automatic cmp(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    placement_t p;
    if (!rst_ni) begin
      atlas_w = 1024;
      atlas_h = 1024;
      border  = 0;
      wipe_skyline();
      placement_q.delete();
      fail_cnt_o = 0;
    end else begin
      if (result_valid_o) begin
        if (placement_q.size() == 0) begin
          $error("result transaction with no expected placement");
          fail_cnt_o++;
        end else begin
          p = placement_q.pop_front();
          cmp("placed", 32'(p.placed), 32'(placed_o));
          cmp("pos_x", 32'(p.pos_x), 32'(pos_x_o));
          cmp("pos_y", 32'(p.pos_y), 32'(pos_y_o));
          cmp("used_width", 32'(p.used_w), 32'(used_width_o));
          cmp("used_height", 32'(p.used_h), 32'(used_height_o));
          cmp("used_width_pow2", 32'(p.used_w_p2), 32'(used_width_pow2_o));
          cmp("used_height_pow2", 32'(p.used_h_p2), 32'(used_height_pow2_o));
          cmp("area_total", 32'(p.area), 32'(area_total_o));
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_ATLAS_WIDTH:  atlas_w = int'(cfg_data_i[10:0]);
          REG_ATLAS_HEIGHT: atlas_h = int'(cfg_data_i[11:0]);
          REG_BORDER_SIZE:  border  = int'(cfg_data_i[3:0]);
          default: ;
        endcase
      end
      if (start && !busy) begin
        predict_placement(cmd_i, int'(block_width_i), int'(block_height_i));
      end
    end
  end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives directed and random add/clear transactions through several atlas
// settings; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;
  import skp_pkg::*;

  localparam int CYCLE_LIMIT = 20_000_000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  cmd = 1'b0;
  logic [11:0]           blk_w = 12'd1;
  logic [11:0]           blk_h = 12'd1;
  logic                  res_valid, placed;
  logic [10:0]           pos_x, used_w_p2;
  logic [12:0]           pos_y, used_h_p2;
  logic signed [11:0]    used_w;
  logic signed [12:0]    used_h;
  logic [AREA_W-1:0]     area;
  int                    fail_cnt;
  int                    sent_cnt = 0;
  int                    rcvd_cnt = 0;
  int                    cycle_cnt = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  skyline_rectangle_packer u_dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .start, .busy,
    .cmd_i(cmd), .block_width_i(blk_w), .block_height_i(blk_h),
    .result_valid_o(res_valid), .placed_o(placed), .pos_x_o(pos_x), .pos_y_o(pos_y),
    .used_width_o(used_w), .used_height_o(used_h),
    .used_width_pow2_o(used_w_p2), .used_height_pow2_o(used_h_p2),
    .area_total_o(area)
  );

  skp_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .start, .busy,
    .cmd_i(cmd), .block_width_i(blk_w), .block_height_i(blk_h),
    .result_valid_o(res_valid), .placed_o(placed), .pos_x_o(pos_x), .pos_y_o(pos_y),
    .used_width_o(used_w), .used_height_o(used_h),
    .used_width_pow2_o(used_w_p2), .used_height_pow2_o(used_h_p2),
    .area_total_o(area), .fail_cnt_o(fail_cnt)
  );

  always @(posedge clk_i) begin
    if (res_valid) rcvd_cnt <= rcvd_cnt + 1;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // called right after a rising edge; returns at the accepting edge
  task automatic issue(input item_cmd_e c, input int w, input int h);
    start <= 1'b1;
    cmd   <= c;
    blk_w <= w[11:0];
    blk_h <= h[11:0];
    do @(posedge clk_i); while (busy);
    sent_cnt++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (rcvd_cnt != sent_cnt) @(posedge clk_i);
  endtask

  // block must be idle: all results in
  task automatic set_atlas(input int w, input int h, input int b);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_ATLAS_WIDTH;
    cfg_data <= w[11:0];
    @(posedge clk_i);
    cfg_idx  <= REG_ATLAS_HEIGHT;
    cfg_data <= h[11:0];
    @(posedge clk_i);
    cfg_idx  <= REG_BORDER_SIZE;
    cfg_data <= b[11:0];
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  int phase_w[7] = '{1024, 1, 1024, 64, 200, 512, 33};
  int phase_h[7] = '{1024, 1, 4095, 300, 4095, 2000, 64};
  int phase_b[7] = '{0, 0, 15, 3, 1, 7, 2};

  initial begin
    int burst, lim, w, h, sel, prev_w, prev_h;
    prev_w = 5;
    prev_h = 5;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, clamping, height bound and the failed-size filter
    issue(CMD_CLEAR, 1, 1);
    issue(CMD_ADD, 1, 1);
    issue(CMD_ADD, 4095, 1);
    issue(CMD_ADD, 1, 4095);
    issue(CMD_ADD, 1, 4095);
    issue(CMD_ADD, 4095, 4095);
    issue(CMD_ADD, 2048, 1000);
    issue(CMD_ADD, 10, 10);
    issue(CMD_ADD, 1023, 1);
    issue(CMD_ADD, 1024, 900);
    issue(CMD_ADD, 3, 3);
    issue(CMD_CLEAR, 4095, 4095);
    issue(CMD_ADD, 2730, 1365);
    drain();
    set_atlas(1024, 4095, 15);
    @(posedge clk_i);
    issue(CMD_ADD, 1, 1);        // border without a clear
    issue(CMD_CLEAR, 1, 1);
    issue(CMD_ADD, 994, 1);
    issue(CMD_ADD, 1, 1);
    issue(CMD_ADD, 4095, 4000);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      set_atlas(phase_w[ph], phase_h[ph], phase_b[ph]);
      @(posedge clk_i);
      issue(CMD_CLEAR, 1, 1);
      for (int n = 0; n < 38; ) begin
        burst = $urandom_range(1, 8);
        for (int k = 0; k < burst; k++, n++) begin
          sel = $urandom_range(0, 99);
          lim = (phase_w[ph] / 8 > 4) ? phase_w[ph] / 8 : 4;
          w = $urandom_range(1, lim);
          h = $urandom_range(1, 40);
          if (sel < 4) begin
            issue(CMD_CLEAR, $urandom_range(1, 4095), $urandom_range(1, 4095));
          end else if (sel < 14) begin
            issue(CMD_ADD, $urandom_range(1, 4095), $urandom_range(1, 4095));
          end else if (sel < 20) begin
            issue(CMD_ADD, prev_w, prev_h);
          end else begin
            issue(CMD_ADD, w, h);
            prev_w = w;
            prev_h = h;
          end
        end
        if ($urandom_range(0, 3) != 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 30)) @(posedge clk_i);
        end
      end
      drain();
    end

    drain();
    repeat (2100) @(posedge clk_i);
    if (fail_cnt == 0 && rcvd_cnt == sent_cnt) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/skp_pkg.sv
hdl/skp_ctrl.sv
hdl/skp_dpath.sv
hdl/skyline_rectangle_packer.sv
test/skp_checker.sv
test/tb_top.sv
